@@ rtl/prtt_pkg.sv @@
package prtt_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_SEND  = 2'd1,
        MODE_REPLY = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OUT_SENT    = 2'd0,
        OUT_MATCHED = 2'd1,
        OUT_UNKNOWN = 2'd2,
        OUT_STARTED = 2'd3
    } outcome_t;

    localparam logic [63:0] RTT_LOW_RESET = 64'd100000000;
    localparam logic [7:0]  SEEN_MAX      = 8'd255;

    typedef struct packed {
        logic [63:0] seq;
        logic [63:0] tstamp;
        logic [7:0]  seen;
    } entry_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [63:0] seq;
        logic [63:0] rtt_us;
        logic        duplicate;
    } result_t;

endpackage

@@ rtl/prtt_ring.sv @@
module prtt_ring
    import prtt_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/ping_sequence_rtt_tracker.sv @@
// Ping round-trip tracker. Each item (session start, send, reply) gives one result item.
// A start or send gives its result from the idle state; no new item is taken until it is read.
// A reply walks the live ring entries newest first. Each examined entry takes a read state
// then a compare state, from the single-port-read ring memory. A match then takes an update
// state and a miss an output state before the result; at most DEPTH-1 entries are live.
// A stalled result holds off the next item. The ring needs no clearing pass; only head/tail
// pointers bound the live entries. Mode 3 items are dropped.
module ping_sequence_rtt_tracker
    import prtt_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // now_us[63:0], reply_seq[127:64]
    input  logic [1:0]    s_tuser,   // mode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [519:0]  m_tdata,   // seq, rtt_us, duplicate, min_rtt, max_rtt,
                                     // rtt_total, sent_total, matched_total,
                                     // replies_in_session, zero pad
    output logic [1:0]    m_tuser    // outcome
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_CMP   = 5'b00100,
        ST_UPD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] head_reg, tail_reg, ptr_reg;
    logic [63:0] next_seq_reg, sess_reg, low_reg, high_reg, acc_reg, sent_reg, match_reg;
    logic [63:0] now_reg, rseq_reg;
    logic [63:0] rtt_reg;
    entry_t      hit_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    logic [63:0] o_low_reg, o_high_reg, o_acc_reg, o_sent_reg, o_match_reg, o_sess_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;
    logic [AW-1:0] head_inc, ptr_dec;
    logic          in_acc;
    logic [1:0]    mode;

    assign head_inc = (head_reg == LAST) ? '0 : head_reg + AW'(1);
    assign ptr_dec  = (ptr_reg == '0) ? LAST : ptr_reg - AW'(1);
    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign mode     = s_tuser;
    assign rd_addr  = ptr_dec;

    prtt_ring #(.DEPTH(DEPTH), .AW(AW)) u_ring (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = '{seq: next_seq_reg, tstamp: s_tdata[63:0], seen: 8'd0};
        if (in_acc && mode == MODE_SEND) begin
            wr_en = 1'b1;
        end else if (state_reg == ST_UPD) begin
            wr_en   = 1'b1;
            wr_addr = ptr_reg;
            wr_data = '{seq: hit_reg.seq, tstamp: hit_reg.tstamp,
                        seen: (hit_reg.seen == SEEN_MAX) ? SEEN_MAX
                                                          : hit_reg.seen + 8'd1};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_acc && mode == MODE_REPLY) state_next = ST_READ;
            ST_READ: state_next = (ptr_reg == tail_reg) ? ST_OUT : ST_CMP;
            ST_CMP:  state_next = (rd_data.seq == rseq_reg) ? ST_UPD : ST_READ;
            ST_UPD:  state_next = ST_IDLE;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            next_seq_reg  <= 64'd1;
            sess_reg      <= '0;
            low_reg       <= RTT_LOW_RESET;
            high_reg      <= '0;
            acc_reg       <= '0;
            sent_reg      <= '0;
            match_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        now_reg  <= s_tdata[63:0];
                        rseq_reg <= s_tdata[127:64];
                        ptr_reg  <= head_reg;
                        case (mode)
                            MODE_START: begin
                                sess_reg <= '0; next_seq_reg <= 64'd1;
                                head_reg <= '0; tail_reg <= '0;
                                res_reg  <= '{OUT_STARTED, 64'd0, 64'd0, 1'b0};
                                o_sess_reg <= '0; o_sent_reg <= sent_reg;
                                o_low_reg <= low_reg; o_high_reg <= high_reg;
                                o_acc_reg <= acc_reg; o_match_reg <= match_reg;
                                out_valid_reg <= 1'b1;
                            end
                            MODE_SEND: begin
                                next_seq_reg <= next_seq_reg + 64'd1;
                                head_reg <= head_inc;
                                if (tail_reg == head_inc) tail_reg <= (tail_reg == LAST) ?
                                    '0 : tail_reg + AW'(1);
                                sent_reg <= sent_reg + 64'd1;
                                res_reg  <= '{OUT_SENT, next_seq_reg, 64'd0, 1'b0};
                                o_sess_reg <= sess_reg; o_sent_reg <= sent_reg + 64'd1;
                                o_low_reg <= low_reg; o_high_reg <= high_reg;
                                o_acc_reg <= acc_reg; o_match_reg <= match_reg;
                                out_valid_reg <= 1'b1;
                            end
                            MODE_REPLY: sess_reg <= sess_reg + 64'd1;
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    // memory is reading entry ptr-1; step pointer onto it
                    if (ptr_reg != tail_reg) ptr_reg <= ptr_dec;
                end
                ST_CMP: begin
                    // keep the entry, the read address already moves on
                    hit_reg <= rd_data;
                    rtt_reg <= now_reg - rd_data.tstamp;
                end
                ST_UPD: begin
                    if (rtt_reg < low_reg) low_reg <= rtt_reg;
                    if (rtt_reg > high_reg) high_reg <= rtt_reg;
                    acc_reg   <= acc_reg + rtt_reg;
                    match_reg <= match_reg + 64'd1;
                    res_reg   <= '{OUT_MATCHED, rseq_reg, rtt_reg, hit_reg.seen != 8'd0};
                    o_low_reg  <= (rtt_reg < low_reg) ? rtt_reg : low_reg;
                    o_high_reg <= (rtt_reg > high_reg) ? rtt_reg : high_reg;
                    o_acc_reg  <= acc_reg + rtt_reg;
                    o_match_reg <= match_reg + 64'd1;
                    o_sent_reg <= sent_reg; o_sess_reg <= sess_reg;
                    out_valid_reg <= 1'b1;
                end
                ST_OUT: begin
                    res_reg <= '{OUT_UNKNOWN, rseq_reg, 64'd0, 1'b0};
                    o_low_reg <= low_reg; o_high_reg <= high_reg;
                    o_acc_reg <= acc_reg; o_match_reg <= match_reg;
                    o_sent_reg <= sent_reg; o_sess_reg <= sess_reg;
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.outcome;
    assign m_tdata  = {7'd0, o_sess_reg, o_match_reg, o_sent_reg, o_acc_reg, o_high_reg,
                       o_low_reg, res_reg.duplicate, res_reg.rtt_us, res_reg.seq};

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    a_upd_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> (hit_reg.seq == rseq_reg))
        else $error("update without match");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import prtt_pkg::*;

    typedef struct {
        mode_t       mode;
        logic [63:0] now_us;
        logic [63:0] reply_seq;
    } ping_item_t;

    typedef struct {
        outcome_t    outcome;
        logic [63:0] seq;
        logic [63:0] rtt_us;
        logic        duplicate;
        logic [63:0] min_rtt;
        logic [63:0] max_rtt;
        logic [63:0] rtt_total;
        logic [63:0] sent_total;
        logic [63:0] matched_total;
        logic [63:0] replies_in_session;
    } ping_result_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [127:0]  s_tdata;   // now_us, reply_seq
    logic [1:0]    s_tuser;   // mode
    logic          m_tvalid;
    logic          m_tready;
    logic [519:0]  m_tdata;   // seq, rtt_us, duplicate, min_rtt, max_rtt, rtt_total,
                              // sent_total, matched_total, replies_in_session, zero pad
    logic [1:0]    m_tuser;   // outcome

    ping_item_t   ping_items[$];
    ping_result_t expected_results[$];
    int           errors;
    int           send_gap;
    int           recv_gap;
    bit           no_idle;

    // tracker model state
    logic [63:0] ring_seq [256];
    logic [63:0] ring_time[256];
    logic [7:0]  ring_seen[256];
    logic [7:0]  head_ptr;
    logic [7:0]  tail_ptr;
    logic [63:0] next_seq;
    logic [63:0] session_replies;
    logic [63:0] rtt_low;
    logic [63:0] rtt_high;
    logic [63:0] rtt_accum;
    logic [63:0] sent_count;
    logic [63:0] matched_count;

    ping_sequence_rtt_tracker uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic track_ping(ping_item_t it);
        ping_result_t r;
        logic [7:0]   n;
        logic [63:0]  rtt;
        bit           found;
        if (it.mode == MODE_NONE) return;
        r = '{OUT_STARTED, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
        case (it.mode)
            MODE_START: begin
                session_replies = 64'd0;
                next_seq = 64'd1;
                head_ptr = 8'd0;
                tail_ptr = 8'd0;
            end
            MODE_SEND: begin
                ring_seq[head_ptr] = next_seq;
                ring_time[head_ptr] = it.now_us;
                ring_seen[head_ptr] = 8'd0;
                r.outcome = OUT_SENT;
                r.seq = next_seq;
                next_seq = next_seq + 64'd1;
                head_ptr = head_ptr + 8'd1;
                if (tail_ptr == head_ptr) tail_ptr = tail_ptr + 8'd1;
                sent_count = sent_count + 64'd1;
            end
            default: begin
                session_replies = session_replies + 64'd1;
                r.seq = it.reply_seq;
                r.outcome = OUT_UNKNOWN;
                n = head_ptr;
                found = 1'b0;
                // newest first, head slot itself is never live
                while (n != tail_ptr && !found) begin
                    n = n - 8'd1;
                    if (ring_seq[n] == it.reply_seq) found = 1'b1;
                end
                if (found) begin
                    rtt = it.now_us - ring_time[n];
                    if (ring_seen[n] < SEEN_MAX) ring_seen[n] = ring_seen[n] + 8'd1;
                    r.outcome = OUT_MATCHED;
                    r.rtt_us = rtt;
                    r.duplicate = ring_seen[n] > 8'd1;
                    if (rtt < rtt_low) rtt_low = rtt;
                    if (rtt > rtt_high) rtt_high = rtt;
                    rtt_accum = rtt_accum + rtt;
                    matched_count = matched_count + 64'd1;
                end
            end
        endcase
        r.min_rtt = rtt_low;
        r.max_rtt = rtt_high;
        r.rtt_total = rtt_accum;
        r.sent_total = sent_count;
        r.matched_total = matched_count;
        r.replies_in_session = session_replies;
        expected_results.push_back(r);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (ping_items.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= ping_items[0].mode;
                s_tdata <= {ping_items[0].reply_seq, ping_items[0].now_us};
                void'(ping_items.pop_front());
                send_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // accepted input items feed the model
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            track_ping('{mode_t'(s_tuser), s_tdata[63:0], s_tdata[127:64]});
    end

    // result side
    always @(posedge aclk) begin
        ping_result_t w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result item, outcome %0d", m_tuser);
                    errors++;
                end else begin
                    w = expected_results.pop_front();
                    if (m_tuser != w.outcome)
                        report_mismatch("outcome", 64'(m_tuser), 64'(w.outcome));
                    if (m_tdata[63:0] != w.seq) report_mismatch("seq", m_tdata[63:0], w.seq);
                    if (m_tdata[127:64] != w.rtt_us)
                        report_mismatch("rtt_us", m_tdata[127:64], w.rtt_us);
                    if (m_tdata[128] != w.duplicate)
                        report_mismatch("duplicate", 64'(m_tdata[128]), 64'(w.duplicate));
                    if (m_tdata[192:129] != w.min_rtt)
                        report_mismatch("min_rtt", m_tdata[192:129], w.min_rtt);
                    if (m_tdata[256:193] != w.max_rtt)
                        report_mismatch("max_rtt", m_tdata[256:193], w.max_rtt);
                    if (m_tdata[320:257] != w.rtt_total)
                        report_mismatch("rtt_total", m_tdata[320:257], w.rtt_total);
                    if (m_tdata[384:321] != w.sent_total)
                        report_mismatch("sent_total", m_tdata[384:321], w.sent_total);
                    if (m_tdata[448:385] != w.matched_total)
                        report_mismatch("matched_total", m_tdata[448:385], w.matched_total);
                    if (m_tdata[512:449] != w.replies_in_session)
                        report_mismatch("replies_in_session", m_tdata[512:449],
                                        w.replies_in_session);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic add_item(mode_t m, logic [63:0] t, logic [63:0] q);
        ping_items.push_back('{m, t, q});
    endtask

    initial begin
        int          count;
        int          r;
        int          span;
        logic [63:0] gen_seq;
        logic [63:0] now;
        logic [63:0] target;
        errors = 0;
        no_idle = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_START;
        m_tready = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        head_ptr = 8'd0;
        tail_ptr = 8'd0;
        next_seq = 64'd1;
        session_replies = 64'd0;
        rtt_low = RTT_LOW_RESET;
        rtt_high = 64'd0;
        rtt_accum = 64'd0;
        sent_count = 64'd0;
        matched_count = 64'd0;

        // directed part
        add_item(MODE_REPLY, 64'd10, 64'd1);         // reply on empty ring
        add_item(MODE_START, 64'd0, 64'd0);
        add_item(MODE_SEND, 64'd0, 64'd0);
        add_item(MODE_SEND, '1, '1);
        add_item(MODE_SEND, 64'd1000, 64'd0);
        add_item(MODE_REPLY, 64'd1500, 64'd3);
        add_item(MODE_REPLY, 64'd1600, 64'd3);       // duplicate
        add_item(MODE_REPLY, 64'd5, 64'd2);          // rtt wraps
        add_item(MODE_REPLY, '1, 64'd1);             // largest rtt
        add_item(MODE_REPLY, 64'd7, '1);             // unknown
        add_item(MODE_REPLY, 64'd7, 64'd0);          // unknown, seq 0 never sent
        add_item(MODE_NONE, '1, '1);                 // ignored
        add_item(MODE_NONE, 64'd0, 64'd1);
        add_item(MODE_START, '1, '1);
        add_item(MODE_REPLY, 64'd8, 64'd1);          // ring emptied by start
        add_item(MODE_SEND, 64'd20, 64'd0);
        add_item(MODE_REPLY, 64'd25, 64'd1);
        add_item(MODE_START, 64'd0, 64'd0);

        // random part
        gen_seq = 64'd1;
        now = 64'd0;
        count = 0;
        while (count < 1030) begin
            r = $urandom_range(0, 999);
            if (count % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0) now = {$urandom, $urandom};
            else now = now + $urandom_range(0, 5000);
            if (count == 200) begin
                // fill the ring past its size so old entries drop out
                repeat (300) begin
                    now = now + $urandom_range(1, 50);
                    add_item(MODE_SEND, now, {$urandom, $urandom});
                    gen_seq = gen_seq + 64'd1;
                end
                add_item(MODE_REPLY, now, gen_seq - 64'd256);
                add_item(MODE_REPLY, now, gen_seq - 64'd255);
                add_item(MODE_REPLY, now, gen_seq - 64'd1);
                count += 303;
            end else if (count == 600) begin
                // drive one seen counter into saturation
                add_item(MODE_SEND, now, 64'd0);
                repeat (260) begin
                    now = now + $urandom_range(0, 9);
                    add_item(MODE_REPLY, now, gen_seq);
                end
                gen_seq = gen_seq + 64'd1;
                count += 261;
            end else if (r < 12) begin
                add_item(MODE_START, {$urandom, $urandom}, {$urandom, $urandom});
                gen_seq = 64'd1;
                count++;
            end else if (r < 40) begin
                add_item(MODE_NONE, {$urandom, $urandom}, {$urandom, $urandom});
            end else if (r < 480) begin
                add_item(MODE_SEND, now, {$urandom, $urandom});
                gen_seq = gen_seq + 64'd1;
                count++;
            end else begin
                if (r < 560 || gen_seq < 64'd2) begin
                    target = {$urandom, $urandom};
                end else begin
                    span = (gen_seq > 64'd300) ? 300 : int'(gen_seq) - 2;
                    target = gen_seq - 64'd1 - $urandom_range(0, span);
                end
                add_item(MODE_REPLY, now, target);
                count++;
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (ping_items.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
